/* src/tbhb_pkg.sv */
`default_nettype none
package tbhb_pkg;

    localparam int TABLE_BITS_DEF = 10;
    localparam int HOME_W         = 16;
    localparam int ENTRY_W        = 59;
    localparam logic [31:0] FIB_MULT = 32'd2654435769;
    localparam logic [2:0]  BACKOFF_MAX = 3'd7;
    localparam logic [7:0]  BASE_RESET  = 8'd4;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_ADD    = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_LOOK,
        BK_ADD
    } bk_state_t;

    typedef struct packed {
        kind_t              kind;
        logic [31:0]        ident;
        logic [9:0]         slot;
        logic [HOME_W-1:0]  home;
    } item_t;

    typedef struct packed {
        logic clearing;
        logic pop;
    } bk_status_t;

endpackage
`default_nettype wire

/* src/tbhb_ram.sv */
`default_nettype none
module tbhb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* src/tbhb_front.sv */
`default_nettype none
module tbhb_front #(
    parameter int TABLE_BITS = tbhb_pkg::TABLE_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           hold,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [1:0]     in_kind,
    input  wire logic [31:0]    in_ident,
    input  wire logic [9:0]     in_slot,
    output logic                q_valid,
    output tbhb_pkg::item_t     q_item,
    input  wire logic           q_pop
);
    tbhb_pkg::item_t q_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [31:0]     prod;
    tbhb_pkg::item_t item_in;
    logic            push;

    // Fibonacci hash: top TABLE_BITS bits of the low product word.
    assign prod = in_ident * tbhb_pkg::FIB_MULT;
    always_comb
    begin
        item_in.kind  = tbhb_pkg::kind_t'(in_kind);
        item_in.ident = in_ident;
        item_in.slot  = in_slot;
        item_in.home  = tbhb_pkg::HOME_W'(prod >> (32 - TABLE_BITS));
    end

    assign in_ready = !hold && (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end
endmodule
`default_nettype wire

/* src/tbhb_back.sv */
`default_nettype none
module tbhb_back #(
    parameter int TABLE_BITS = tbhb_pkg::TABLE_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [7:0]       base_lifetime,
    input  wire logic             q_valid,
    input  wire tbhb_pkg::item_t  q_item,
    output logic                  q_pop,
    output tbhb_pkg::bk_status_t  status,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  out_found,
    output logic [9:0]            out_slot,
    output logic [10:0]           out_count
);
    localparam int TB = TABLE_BITS;
    localparam logic [TB:0]   SIZE     = (TB+1)'(1) << TB;
    localparam logic [TB-1:0] LAST_ROW = {TB{1'b1}};

    tbhb_pkg::bk_state_t state_reg, state_next;
    logic [TB-1:0] clr_reg, clr_next;
    logic [TB-1:0] pos_reg, pos_next;
    logic [TB-1:0] reuse_reg, reuse_next;
    logic          have_reg, have_next;
    logic [TB:0]   cnt_reg, cnt_next;
    logic [TB:0]   fill_reg, fill_next;
    logic [7:0]    tick_reg, tick_next;
    logic [31:0]   ident_reg, ident_next;
    logic          ovalid_reg, ovalid_next;
    logic          ofound_reg, ofound_next;
    logic [9:0]    oslot_reg, oslot_next;
    logic [10:0]   ocount_reg, ocount_next;

    logic                        we;
    logic [TB-1:0]               waddr, raddr;
    logic [tbhb_pkg::ENTRY_W-1:0] wdata, rdata;

    logic [31:0] e_id;
    logic [7:0]  e_born, e_seen, e_ttl, age_born, age_seen;
    logic [2:0]  e_expo, expo_up;
    logic [15:0] ttl_wide;
    logic        stale, out_free;
    logic [TB-1:0] pos_inc;

    tbhb_ram #(.WIDTH(tbhb_pkg::ENTRY_W), .DEPTH(1 << TB)) u_table (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign e_id     = rdata[58:27];
    assign e_born   = rdata[26:19];
    assign e_seen   = rdata[18:11];
    assign e_ttl    = rdata[10:3];
    assign e_expo   = rdata[2:0];
    assign age_born = tick_reg - e_born;
    assign age_seen = tick_reg - e_seen;
    assign stale    = (age_born >= e_ttl) || (age_seen > 8'd1);
    assign expo_up  = (e_expo < tbhb_pkg::BACKOFF_MAX) ? e_expo + 3'd1 : e_expo;
    assign ttl_wide = {8'd0, base_lifetime} << expo_up;
    assign pos_inc  = pos_reg + TB'(1);
    assign out_free = !ovalid_reg || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        pos_next    = pos_reg;
        reuse_next  = reuse_reg;
        have_next   = have_reg;
        cnt_next    = cnt_reg;
        fill_next   = fill_reg;
        tick_next   = tick_reg;
        ident_next  = ident_reg;
        ovalid_next = ovalid_reg && !out_ready;
        ofound_next = ofound_reg;
        oslot_next  = oslot_reg;
        ocount_next = ocount_reg;
        q_pop       = 1'b0;
        we          = 1'b0;
        waddr       = pos_reg;
        wdata       = '0;
        raddr       = pos_inc;

        unique case (state_reg)
            tbhb_pkg::BK_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + TB'(1);
                if (clr_reg == LAST_ROW)
                begin
                    state_next = tbhb_pkg::BK_IDLE;
                end
            end
            tbhb_pkg::BK_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop      = 1'b1;
                    ident_next = q_item.ident;
                    unique case (q_item.kind)
                        tbhb_pkg::KIND_TICK:
                        begin
                            tick_next   = tick_reg + 8'd1;
                            ovalid_next = 1'b1;
                            ofound_next = 1'b0;
                            oslot_next  = '0;
                            ocount_next = 11'(fill_reg);
                        end
                        tbhb_pkg::KIND_LOOKUP:
                        begin
                            raddr      = TB'(q_item.home);
                            pos_next   = TB'(q_item.home);
                            cnt_next   = '0;
                            have_next  = 1'b0;
                            state_next = tbhb_pkg::BK_LOOK;
                        end
                        tbhb_pkg::KIND_ADD:
                        begin
                            raddr      = TB'(q_item.slot);
                            pos_next   = TB'(q_item.slot);
                            state_next = tbhb_pkg::BK_ADD;
                        end
                        default:
                        begin
                            ovalid_next = 1'b1;
                            ofound_next = 1'b0;
                            oslot_next  = '0;
                            ocount_next = 11'(fill_reg);
                        end
                    endcase
                end
            end
            tbhb_pkg::BK_LOOK:
            begin
                ofound_next = 1'b0;
                ocount_next = 11'(fill_reg);
                if (e_id == 32'd0)
                begin
                    ovalid_next = 1'b1;
                    oslot_next  = 10'(have_reg ? reuse_reg : pos_reg);
                    state_next  = tbhb_pkg::BK_IDLE;
                end
                else if (e_id == ident_reg)
                begin
                    ovalid_next = 1'b1;
                    oslot_next  = 10'(pos_reg);
                    state_next  = tbhb_pkg::BK_IDLE;
                    if (!stale)
                    begin
                        // Live hit: refresh the last-seen time.
                        ofound_next = 1'b1;
                        we          = 1'b1;
                        wdata       = {rdata[58:19], tick_reg, rdata[10:0]};
                    end
                end
                else
                begin
                    if (stale && !have_reg)
                    begin
                        reuse_next = pos_reg;
                        have_next  = 1'b1;
                    end
                    cnt_next = cnt_reg + (TB+1)'(1);
                    pos_next = pos_inc;
                    if (cnt_next == SIZE)
                    begin
                        // Whole table walked: answer with the home slot.
                        ovalid_next = 1'b1;
                        oslot_next  = 10'(pos_inc);
                        state_next  = tbhb_pkg::BK_IDLE;
                    end
                end
            end
            tbhb_pkg::BK_ADD:
            begin
                we          = 1'b1;
                ovalid_next = 1'b1;
                ofound_next = 1'b0;
                oslot_next  = 10'(pos_reg);
                state_next  = tbhb_pkg::BK_IDLE;
                if (e_id == ident_reg)
                begin
                    wdata = {e_id, tick_reg, tick_reg, ttl_wide[7:0], expo_up};
                end
                else
                begin
                    wdata = {ident_reg, tick_reg, tick_reg, base_lifetime, 3'd1};
                    if (fill_reg < SIZE)
                    begin
                        fill_next = fill_reg + (TB+1)'(1);
                    end
                end
                ocount_next = 11'(fill_next);
            end
            default:
            begin
                state_next = tbhb_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        reuse_reg  <= reuse_next;
        cnt_reg    <= cnt_next;
        ident_reg  <= ident_next;
        ofound_reg <= ofound_next;
        oslot_reg  <= oslot_next;
        ocount_reg <= ocount_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tbhb_pkg::BK_CLEAR;
            clr_reg    <= '0;
            have_reg   <= 1'b0;
            fill_reg   <= '0;
            tick_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            have_reg   <= have_next;
            fill_reg   <= fill_next;
            tick_reg   <= tick_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign status.clearing = (state_reg == tbhb_pkg::BK_CLEAR);
    assign status.pop      = q_pop;
    assign out_valid = ovalid_reg;
    assign out_found = ofound_reg;
    assign out_slot  = oslot_reg;
    assign out_count = ocount_reg;
endmodule
`default_nettype wire

/* src/ttl_backoff_hash_blocklist_core.sv */
`default_nettype none
// Blocklist of 2^TABLE_BITS entries with tick, lookup and add words. After reset the
// table is swept to empty, one entry per cycle, before the first input word is taken.
// A tick goes from the input queue into the output register; an add reads its slot, then
// writes it and the result; a lookup walks slot by slot from its home slot, since the
// single read port of the table memory delivers one entry per cycle. A two-word input
// queue lets new words arrive while a result waits in the output register.
module ttl_backoff_hash_blocklist_core #(
    parameter int TABLE_BITS = tbhb_pkg::TABLE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,      // base_lifetime
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,       // ident [31:0], slot [41:32], zero pad
    input  wire logic [1:0]  s_tuser,       // kind [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,       // result_slot [9:0], entry_count [20:10], pad
    output logic             m_tuser        // found
);
    logic                 [7:0] base_reg;
    logic                       q_valid;
    tbhb_pkg::item_t            q_item;
    logic                       pop;
    tbhb_pkg::bk_status_t       status;
    logic [9:0]                 res_slot;
    logic [10:0]                res_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= tbhb_pkg::BASE_RESET;
        end
        else if (cfg_valid)
        begin
            base_reg <= cfg_data;
        end
    end

    tbhb_front #(.TABLE_BITS(TABLE_BITS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .hold    (status.clearing),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .in_kind (s_tuser),
        .in_ident(s_tdata[31:0]),
        .in_slot (s_tdata[41:32]),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (pop)
    );

    tbhb_back #(.TABLE_BITS(TABLE_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .base_lifetime(base_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (pop),
        .status       (status),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_found    (m_tuser),
        .out_slot     (res_slot),
        .out_count    (res_count)
    );

    assign m_tdata = {3'd0, res_count, res_slot};

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !s_tready)
        else $error("input accepted during table clear");

    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        status.pop |-> !status.clearing)
        else $error("queue popped during table clear");

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (status.pop && m_tvalid) |-> m_tready)
        else $error("item started while output register full");
endmodule
`default_nettype wire

/* bench/tb.sv */
`default_nettype none
module tb;
    import tbhb_pkg::*;

    localparam int TBITS = 10;
    localparam int TSIZE = 1 << TBITS;
    localparam int WATCH_LIMIT = 6000;
    localparam int LONG_HOLD = 300;

    typedef struct {
        bit found;
        bit [9:0] rslot;
        bit [10:0] count;
    } answer_t;

    typedef struct {
        kind_t kind;
        bit [31:0] ident;
        bit [9:0] slot;
        bit typed;
        answer_t ans;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_data = 8'd0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [47:0] s_tdata = 48'd0;
    logic [1:0] s_tuser = 2'd0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic m_tuser;

    ttl_backoff_hash_blocklist_core #(.TABLE_BITS(TBITS)) uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mirror of the blocklist state.
    bit [31:0] ent_id [TSIZE];
    bit [7:0] ent_born [TSIZE];
    bit [7:0] ent_seen [TSIZE];
    bit [7:0] ent_ttl [TSIZE];
    bit [2:0] ent_expo [TSIZE];
    bit [7:0] ticks;
    bit [10:0] fill;
    bit [7:0] lifetime = BASE_RESET;

    answer_t pending[$];
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int found_hits = 0;
    bit idle_on = 1'b0;
    bit hold_req = 1'b0;
    bit [31:0] pool [48];
    bit [31:0] filled_ids [TSIZE];

    function automatic bit [9:0] home_slot(bit [31:0] id);
        bit [31:0] prod;
        prod = id * FIB_MULT;
        return prod[31:32-TBITS];
    endfunction

    function automatic bit is_stale(int p);
        bit [7:0] age;
        bit [7:0] since;
        age = ticks - ent_born[p];
        since = ticks - ent_seen[p];
        return (age >= ent_ttl[p]) || (since > 8'd1);
    endfunction

    // Walks the probe run; refreshes the seen time only when commit is set.
    function automatic bit probe_run(bit [31:0] id, bit commit, output bit [9:0] where);
        bit [9:0] pos;
        bit [9:0] reuse;
        bit have_reuse;
        bit st;
        pos = home_slot(id);
        have_reuse = 1'b0;
        reuse = '0;
        where = pos;
        if (ent_id[pos] == 32'd0)
            return 1'b0;
        for (int n = 0; n < TSIZE; n++)
        begin
            st = is_stale(pos);
            if (ent_id[pos] == id)
            begin
                where = pos;
                if (st)
                    return 1'b0;
                if (commit)
                    ent_seen[pos] = ticks;
                return 1'b1;
            end
            if (st && !have_reuse)
            begin
                reuse = pos;
                have_reuse = 1'b1;
            end
            pos = pos + 10'd1;
            if (ent_id[pos] == 32'd0)
            begin
                where = have_reuse ? reuse : pos;
                return 1'b0;
            end
        end
        where = pos;
        return 1'b0;
    endfunction

    function automatic answer_t blocklist_step(kind_t kind, bit [31:0] id, bit [9:0] slot);
        answer_t a;
        bit [9:0] w;
        a.found = 1'b0;
        a.rslot = '0;
        case (kind)
            KIND_TICK: ticks = ticks + 8'd1;
            KIND_LOOKUP:
            begin
                a.found = probe_run(id, 1'b1, w);
                a.rslot = w;
            end
            KIND_ADD:
            begin
                a.rslot = slot;
                if (ent_id[slot] == id)
                begin
                    if (ent_expo[slot] < BACKOFF_MAX)
                        ent_expo[slot] = ent_expo[slot] + 3'd1;
                    ent_born[slot] = ticks;
                    ent_seen[slot] = ticks;
                    ent_ttl[slot] = 8'(16'(lifetime) << ent_expo[slot]);
                end
                else
                begin
                    ent_id[slot] = id;
                    ent_born[slot] = ticks;
                    ent_seen[slot] = ticks;
                    ent_ttl[slot] = lifetime;
                    ent_expo[slot] = 3'd1;
                    if (fill < 11'(TSIZE))
                        fill = fill + 11'd1;
                end
            end
            default: ;
        endcase
        a.count = fill;
        return a;
    endfunction

    task automatic send_word(kind_t kind, bit [31:0] id, bit [9:0] slot, bit typed,
                             answer_t typed_ans);
        answer_t a;
        if (idle_on && ($urandom_range(0, 7) == 0))
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {6'd0, slot, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        a = blocklist_step(kind, id, slot);
        if (kind == KIND_LOOKUP && a.found)
            found_hits++;
        pending.push_back(typed ? typed_ans : a);
        words_in++;
    endtask

    task automatic write_lifetime(bit [7:0] val);
        s_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        lifetime = val;
    endtask

    function automatic bit [31:0] pick_id();
        if ($urandom_range(0, 99) < 85)
            return pool[$urandom_range(0, 47)];
        return $urandom;
    endfunction

    task automatic random_words(int count);
        int r;
        bit [31:0] id;
        bit [9:0] w;
        bit dummy;
        answer_t none;
        none = '{default: 0};
        foreach (pool[i])
            pool[i] = $urandom;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            id = pick_id();
            if (r < 25)
                send_word(KIND_TICK, id, 10'($urandom), 1'b0, none);
            else if (r < 62)
                send_word(KIND_LOOKUP, id, 10'($urandom), 1'b0, none);
            else if (r < 90)
            begin
                // Well-formed add: use the slot a lookup would report right now.
                dummy = probe_run(id, 1'b0, w);
                send_word(KIND_ADD, id, w, 1'b0, none);
            end
            else if (r < 96)
                send_word(KIND_ADD, id, 10'($urandom), 1'b0, none);
            else
                send_word(KIND_NONE, id, 10'($urandom), 1'b0, none);
        end
    endtask

    row_t directed [$];

    function automatic row_t mk(kind_t k, bit [31:0] id, bit [9:0] s, bit t,
                                bit f, bit [9:0] rs, bit [10:0] c);
        row_t r;
        r.kind = k;
        r.ident = id;
        r.slot = s;
        r.typed = t;
        r.ans.found = f;
        r.ans.rslot = rs;
        r.ans.count = c;
        return r;
    endfunction

    // Result checker.
    always @(posedge clk)
    begin
        answer_t e;
        if (m_tvalid && m_tready)
        begin
            words_out++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result found=%0d slot=%0d count=%0d",
                         $time, m_tuser, m_tdata[9:0], m_tdata[20:10]);
                errors++;
            end
            else
            begin
                e = pending.pop_front();
                if (m_tuser !== e.found || m_tdata[9:0] !== e.rslot
                    || m_tdata[20:10] !== e.count)
                begin
                    $display("%0t: mismatch expected found=%0d slot=%0d count=%0d, got %0d %0d %0d",
                             $time, e.found, e.rslot, e.count,
                             m_tuser, m_tdata[9:0], m_tdata[20:10]);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold to back up the input.
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge clk)
    begin
        bit nxt;
        nxt = 1'b1;
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            nxt = 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            nxt = 1'b0;
        end
        else if (idle_on && ($urandom_range(0, 9) == 0))
        begin
            hold_left = $urandom_range(1, 17) - 1;
            nxt = 1'b0;
        end
        m_tready <= nxt;
    end

    int quiet = 0;
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet = quiet + 1;
        if (quiet >= WATCH_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        answer_t none;
        bit [31:0] id;
        none = '{default: 0};
        ticks = '0;
        fill = '0;
        foreach (ent_id[i])
        begin
            ent_id[i] = '0;
            ent_born[i] = '0;
            ent_seen[i] = '0;
            ent_ttl[i] = '0;
            ent_expo[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        directed.push_back(mk(KIND_TICK, 32'd0, 10'd0, 1, 0, 10'd0, 11'd0));
        directed.push_back(mk(KIND_NONE, 32'hFFFFFFFF, 10'h3FF, 1, 0, 10'd0, 11'd0));
        // Adding id zero to an empty slot leaves it empty.
        directed.push_back(mk(KIND_ADD, 32'd0, 10'h3FF, 1, 0, 10'd1023, 11'd0));
        directed.push_back(mk(KIND_LOOKUP, 32'd0, 10'd0, 1, 0, 10'd0, 11'd0));
        directed.push_back(mk(KIND_ADD, 32'hFFFFFFFF, 10'h3FF, 1, 0, 10'd1023, 11'd1));
        directed.push_back(mk(KIND_LOOKUP, 32'hFFFFFFFF, 10'd0, 0, 0, 10'd0, 11'd0));
        directed.push_back(mk(KIND_ADD, 32'hFFFFFFFF, 10'h3FF, 1, 0, 10'd1023, 11'd1));
        directed.push_back(mk(KIND_NONE, 32'd0, 10'd0, 1, 0, 10'd0, 11'd1));
        directed.push_back(mk(KIND_TICK, 32'd0, 10'd0, 1, 0, 10'd0, 11'd1));
        directed.push_back(mk(KIND_LOOKUP, 32'hFFFFFFFF, 10'd0, 0, 0, 10'd0, 11'd0));
        directed.push_back(mk(KIND_ADD, 32'd1, 10'd0, 1, 0, 10'd0, 11'd2));
        directed.push_back(mk(KIND_ADD, 32'h80000000, 10'd200, 1, 0, 10'd200, 11'd3));
        // Repeated adds push the backoff exponent to its ceiling.
        repeat (7)
            directed.push_back(mk(KIND_ADD, 32'h80000000, 10'd200, 1, 0, 10'd200, 11'd3));
        directed.push_back(mk(KIND_LOOKUP, 32'h80000000, 10'd0, 0, 0, 10'd0, 11'd0));
        directed.push_back(mk(KIND_ADD, 32'h12345678, 10'd0, 1, 0, 10'd0, 11'd4));
        directed.push_back(mk(KIND_TICK, 32'd0, 10'd0, 1, 0, 10'd0, 11'd4));
        directed.push_back(mk(KIND_TICK, 32'd0, 10'd0, 1, 0, 10'd0, 11'd4));
        directed.push_back(mk(KIND_LOOKUP, 32'h12345678, 10'd0, 0, 0, 10'd0, 11'd0));
        foreach (directed[i])
            send_word(directed[i].kind, directed[i].ident, directed[i].slot,
                      directed[i].typed, directed[i].ans);

        write_lifetime(8'd255);
        idle_on = 1'b1;
        hold_req = 1'b1;
        random_words(250);
        write_lifetime(8'd0);
        random_words(150);
        write_lifetime(8'd1);
        random_words(150);
        idle_on = 1'b0;
        random_words(100);
        idle_on = 1'b1;
        write_lifetime(8'd3);
        random_words(120);

        // Final part, no idling: fill every slot, saturate the count, probe a full table.
        idle_on = 1'b0;
        write_lifetime(8'($urandom_range(2, 254)));
        for (int s = 0; s < TSIZE; s++)
        begin
            filled_ids[s] = $urandom | 32'd1;
            send_word(KIND_ADD, filled_ids[s], 10'(s), 1'b0, none);
        end
        repeat (20)
            send_word(KIND_ADD, $urandom | 32'd1, 10'($urandom), 1'b0, none);
        for (int i = 0; i < 60; i++)
        begin
            id = ($urandom_range(0, 1) != 0) ? filled_ids[$urandom_range(0, TSIZE - 1)]
                                              : $urandom;
            if ($urandom_range(0, 4) == 0)
                send_word(KIND_TICK, id, 10'd0, 1'b0, none);
            else
                send_word(KIND_LOOKUP, id, 10'd0, 1'b0, none);
        end
        s_tvalid <= 1'b0;

        while (pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Sent %0d words and checked %0d results, %0d lookup hits.",
                 words_in, words_out, found_hits);
        $display("Lifetimes 4, 255, 0, 1, 3 and one random value; full table reached.");
        if (errors == 0 && pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
